### sv/pbsv_pkg.sv
// Package for the polyBLEP saw voice: shared widths, constants, state codes
// and the structs passed between the sequencer, the multiplier and the divider.
// No dependencies.
package pbsv_pkg;

  // Fixed stream and configuration widths.
  localparam int IN_W      = 24;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL      = 1'b1;

  // Register reset values and limits.
  localparam logic [CFG_W-1:0] STEP_RESET  = 31'd39370534;
  localparam logic [15:0]      LEVEL_MIN   = 16'd1638;
  localparam logic [15:0]      LEVEL_MAX   = 16'd32768;
  localparam logic [15:0]      LEVEL_RESET = 16'd22938;

  // Shared multiplier operand widths.
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // 0.4 in Q0.16.
  localparam logic signed [MUL_B_W-1:0] GAIN_Q16 = 18'sd26214;

  // Quotient bits of the correction ratio (Q0.16).
  localparam int Q_W = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SQ,
    ST_BLEP,
    ST_FILT,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
    logic                      sh16;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/pbsv_mul.sv
// Shared signed multiplier with a floor shift by 15 or 16 and a registered result.
// Depends on pbsv_pkg.
module pbsv_mul (
  input  logic                                   clk,
  input  pbsv_pkg::mul_req_t                     req,
  output logic signed [pbsv_pkg::MUL_A_W-1:0]    p
);
  import pbsv_pkg::*;

  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] shifted;

  assign prod    = req.a * req.b;
  assign shifted = req.sh16 ? (prod >>> 16) : (prod >>> 15);

  always_ff @(posedge clk) begin
    p <= shifted[MUL_A_W-1:0];
  end

endmodule

### sv/pbsv_div.sv
// Restoring divider, one quotient bit per cycle, for num < den giving
// floor(num * 2^16 / den). Depends on pbsv_pkg.
module pbsv_div #(
  parameter int W = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [W-1:0]                num,
  input  logic [W-1:0]                den,
  output pbsv_pkg::div_stat_t         stat,
  output logic [pbsv_pkg::Q_W-1:0]    quo
);
  import pbsv_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;
  logic [W:0]       rem2;
  logic [W:0]       trial;
  logic             fits;
  logic [CNT_W-1:0] cnt;

  assign rem2  = {rem, 1'b0};
  assign trial = rem2 - {1'b0, dvs};
  assign fits  = !trial[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        rem       <= num;
        dvs       <= den;
        cnt       <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem <= fits ? trial[W-1:0] : rem2[W-1:0];
        quo <= {quo[Q_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(Q_W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/polyblep_saw_voice_top.sv
// Top level of one polyBLEP sawtooth voice with a one-pole lowpass and gain.
// Depends on pbsv_pkg, pbsv_div and pbsv_mul.
//
// Each input beat is one sample tick and yields exactly one output beat. The
// block takes one tick at a time and drops s_tready while it works. An
// inactive tick goes from accept through the check step straight to the
// output step. An active tick away from the wrap goes through the check, the
// filter update, three passes through the shared multiplier and saturation.
// An active tick within one phase step of the wrap first finds the
// correction ratio with a restoring divider that produces one of its 16
// quotient bits per cycle, followed by a square on the multiplier.
// The finished sample sits in an output register, so a stalled m_tready only
// delays the return to idle once a second result is ready. Configuration
// (phase step at index 0, level at index 1) is written through cfg_en,
// cfg_index and cfg_data; the level is clamped to 0.05 .. 1.0 on write and
// the phase step is cut to the phase width if narrower. A restart flag clears
// the phase and the filter before the tick, even when that tick is inactive.
module polyblep_saw_voice_top #(
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_en,
  input  logic [pbsv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbsv_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata fields from bit 0: restart (1), active (1), envelope (17), zero pad.
  input  logic [pbsv_pkg::IN_W-1:0]            s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata fields from bit 0: sample (SAMPLE_BITS, signed), zero pad.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata
);
  import pbsv_pkg::*;

  localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int STEP_W = (PHASE_BITS < CFG_W) ? PHASE_BITS : CFG_W;
  localparam int RSH    = (SAMPLE_BITS <= 17) ? 17 - SAMPLE_BITS : 0;
  localparam int LSH    = (SAMPLE_BITS > 17) ? SAMPLE_BITS - 17 : 0;
  localparam int SCL_W  = MUL_A_W + LSH;
  localparam logic signed [SCL_W-1:0] SAT_HI =
    SCL_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SCL_W-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers.
  logic [STEP_W-1:0] phase_step;
  logic [15:0]       level;
  logic [15:0]       lvl_in;
  logic [15:0]       lvl_clamp;

  // Voice state and per-tick registers.
  state_t                    state;
  state_t                    state_next;
  logic [PHASE_BITS-1:0]     phase;
  logic signed [19:0]        filter;
  logic                      act;
  logic [16:0]               env;
  logic                      late;
  logic signed [18:0]        blep;
  logic signed [SAMPLE_BITS-1:0] res;

  // Datapath helpers.
  logic [PHASE_BITS-1:0]     step_ext;
  logic [PHASE_BITS-1:0]     neg_phase;
  logic                      early;
  logic                      lateh;
  logic signed [18:0]        two_x;
  logic signed [18:0]        sq19;
  logic signed [18:0]        blep_calc;
  logic [15:0]               hi16;
  logic signed [19:0]        saw;
  logic signed [20:0]        diff;
  logic signed [19:0]        filter_next;
  logic signed [SCL_W-1:0]   scl;
  logic signed [SAMPLE_BITS-1:0] res_sat;

  // Shared units.
  logic                      div_start;
  div_stat_t                 div_stat;
  logic [Q_W-1:0]            quo;
  mul_req_t                  mul_req;
  logic signed [MUL_A_W-1:0] mul_p;

  pbsv_div #(.W(PHASE_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (early ? phase : neg_phase),
    .den   (step_ext),
    .stat  (div_stat),
    .quo   (quo)
  );

  pbsv_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .p   (mul_p)
  );

  // Level is clamped to 0.05 .. 1.0 on the way in.
  assign lvl_in    = cfg_data[15:0];
  assign lvl_clamp = (lvl_in < LEVEL_MIN) ? LEVEL_MIN :
                     (lvl_in > LEVEL_MAX) ? LEVEL_MAX : lvl_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET[STEP_W-1:0];
      level      <= LEVEL_RESET;
    end else if (cfg_en) begin
      if (cfg_index == CFG_PHASE_STEP) begin
        phase_step <= cfg_data[STEP_W-1:0];
      end
      if (cfg_index == CFG_LEVEL) begin
        level <= lvl_clamp;
      end
    end
  end

  // Correction regions: just after the wrap (t < dt) wins over just before it.
  assign step_ext  = PHASE_BITS'(phase_step);
  assign neg_phase = -phase;
  assign early     = (|phase_step) && (phase < step_ext);
  assign lateh     = (|phase_step) && !early && (neg_phase < step_ext);

  // polyBLEP term from the ratio x and its square (already shifted by 16).
  assign two_x     = $signed({2'b00, quo, 1'b0});
  assign sq19      = mul_p[18:0];
  assign blep_calc = late ? (sq19 - two_x + 19'sd65536)
                          : (two_x - sq19 - 19'sd65536);

  // Naive saw 2*phase - 1 in Q16, less the correction, then the lowpass.
  assign hi16        = phase[PHASE_BITS-1 -: 16];
  assign saw         = $signed({3'b000, hi16, 1'b0}) - 20'sd65536 - 20'(blep);
  assign diff        = 21'(saw) - 21'(filter);
  assign filter_next = filter + 20'(diff >>> 2);

  // Final scaling to the sample width and saturation.
  assign scl     = (SCL_W'(mul_p) >>> RSH) <<< LSH;
  assign res_sat = (scl > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                   (scl < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] :
                   scl[SAMPLE_BITS-1:0];

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and requests to the shared units.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    mul_req    = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!act) begin
          state_next = ST_DONE;
        end else if (early || lateh) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_FILT;
        end
      end
      ST_DIV: begin
        if (div_stat.done && !div_stat.busy) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_req.a    = $signed({5'b00000, quo});
        mul_req.b    = $signed({2'b00, quo});
        mul_req.sh16 = 1'b1;
        state_next   = ST_BLEP;
      end
      ST_BLEP: begin
        state_next = ST_FILT;
      end
      ST_FILT: begin
        state_next = ST_M1;
      end
      ST_M1: begin
        mul_req.a    = MUL_A_W'(filter);
        mul_req.b    = $signed({1'b0, env});
        mul_req.sh16 = 1'b1;
        state_next   = ST_M2;
      end
      ST_M2: begin
        mul_req.a    = mul_p;
        mul_req.b    = $signed({2'b00, level});
        mul_req.sh16 = 1'b0;
        state_next   = ST_M3;
      end
      ST_M3: begin
        mul_req.a    = mul_p;
        mul_req.b    = GAIN_Q16;
        mul_req.sh16 = 1'b1;
        state_next   = ST_SAT;
      end
      ST_SAT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Voice state: phase and filter are cleared by reset and by restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      filter <= '0;
    end else begin
      if (state == ST_IDLE && s_tvalid && s_tdata[0]) begin
        phase  <= '0;
        filter <= '0;
      end
      if (state == ST_FILT) begin
        filter <= filter_next;
        phase  <= phase + step_ext;
      end
    end
  end

  // Per-tick payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        act <= s_tdata[1];
        env <= s_tdata[18:2];
      end
      ST_CHECK: begin
        late <= lateh;
        blep <= '0;
        res  <= '0;
      end
      ST_BLEP: begin
        blep <= blep_calc;
      end
      ST_SAT: begin
        res <= res_sat;
      end
      default: begin
      end
    endcase
  end

  // Output register: one beat per tick, held while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= OUT_W'($unsigned(res));
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### sv/pbsv_checker.sv
// Port-level checks for the voice top level and the bind that attaches them.
// Depends on polyblep_saw_voice_top.
module pbsv_checker #(
  parameter int OUT_W = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A stalled output beat keeps its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // The voice works on one tick at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after an accepted tick");

  // Reset leaves the block idle with no pending result.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // A new result appears exactly as the sequencer returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result shown while the sequencer is busy");

endmodule

bind polyblep_saw_voice_top pbsv_checker #(.OUT_W(((SAMPLE_BITS + 7) / 8) * 8)) u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
